// ===== hdl/mmd_pkg.sv =====
// Shared types, constants and address decode functions of the memory map decoder.
package mmd_pkg;

   localparam int BANK_BYTES  = 8192;
   localparam int HIGH_BYTES  = 128;
   localparam int OAM_BYTES   = 160;
   localparam int IO_BYTES    = 128;
   localparam int BANK_AW     = $clog2(BANK_BYTES);
   localparam int HIGH_AW     = $clog2(HIGH_BYTES);
   localparam int OAM_AW      = $clog2(OAM_BYTES);
   localparam int IO_AW       = $clog2(IO_BYTES);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ADDR_DMA = 16'hFF46;
   localparam logic [15:0] ADDR_DIV = 16'hFF04;
   localparam logic        KIND_READ  = 1'b0;
   localparam logic        KIND_WRITE = 1'b1;
   localparam logic [7:0]  OPEN_BUS   = 8'hFF;

   typedef enum logic [3:0] {
      RGN_CART, RGN_VRAM, RGN_WRAM, RGN_OAM, RGN_VOID,
      RGN_JOYPAD, RGN_IO, RGN_HRAM, RGN_IE
   } region_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_DMA_RD, ST_DMA_WR
   } state_type;

   typedef enum logic [1:0] {
      FWD_NONE, FWD_CART, FWD_JOYPAD, FWD_AUDIO
   } fwd_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [7:0]  data;
      region_type  region;
   } entry_type;

   function automatic region_type region_of(input logic [15:0] a);
      region_type r;
      case (a) inside
         [16'h0000:16'h7FFF], [16'hA000:16'hBFFF]: r = RGN_CART;
         [16'h8000:16'h9FFF]: r = RGN_VRAM;
         [16'hC000:16'hFDFF]: r = RGN_WRAM;
         [16'hFE00:16'hFE9F]: r = RGN_OAM;
         [16'hFEA0:16'hFEFF]: r = RGN_VOID;
         16'hFF00:            r = RGN_JOYPAD;
         [16'hFF01:16'hFF7F]: r = RGN_IO;
         [16'hFF80:16'hFFFE]: r = RGN_HRAM;
         default:             r = RGN_IE;
      endcase
      return r;
   endfunction

   function automatic logic io_readable(input logic [IO_AW-1:0] off);
      logic ok;
      case (off) inside
         [7'h04:7'h07], 7'h0F, [7'h10:7'h3F], [7'h40:7'h4B],
         [7'h4F:7'h53], [7'h68:7'h7F]: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic is_audio(input logic [15:0] a);
      return (a >= 16'hFF10) && (a <= 16'hFF3F);
   endfunction

   // Audio boot values of the I/O file.
   function automatic logic [7:0] io_default(input logic [IO_AW-1:0] off);
      logic [7:0] v;
      case (off)
         7'h10: v = 8'h80;
         7'h11: v = 8'hBF;
         7'h12: v = 8'hF3;
         7'h14: v = 8'hBF;
         7'h16: v = 8'h3F;
         7'h19: v = 8'hBF;
         7'h1A: v = 8'h7F;
         7'h1B: v = 8'hFF;
         7'h1C: v = 8'h9F;
         7'h1E: v = 8'hBF;
         7'h20: v = 8'hFF;
         7'h23: v = 8'hBF;
         7'h24: v = 8'h77;
         7'h25: v = 8'hF3;
         7'h26: v = 8'hF1;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/memory_map_decoder_with_dma_core.sv =====
// Top level of the memory map decoder with object RAM DMA.
// A write transaction's result is registered when the back end takes it from the queue; a read
// first passes through the fetch state for the registered memory read. The back end takes the
// next transaction only after the result register drains. A DMA write then holds the back end
// in the DMA read and write states for each of the DMA_LENGTH bytes. After reset, with req_ready
// low, the memories are zeroed and the I/O file gets its boot values before the first transaction.
module memory_map_decoder_with_dma_core #(
   parameter int DMA_LENGTH = 160
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_forward_target,
   output logic        rsp_forward_is_write,
   output logic [15:0] rsp_forward_address,
   output logic [7:0]  rsp_forward_data
);
   import mmd_pkg::*;

   // The front end decodes each transaction's region and queues it; the back end
   // owns every store and executes one queued transaction at a time.
   entry_type push_entry, head;
   logic      push, pop, queue_full, queue_empty, clearing;

   mmd_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .queue_full     (queue_full),
      .clearing       (clearing),
      .push           (push),
      .push_entry     (push_entry)
   );

   // The queue lets the front keep accepting while a result waits on the rsp side.
   mmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // The back end holds the result register, so a stalled consumer only stops
   // it from taking the next queued transaction.
   mmd_back #(
      .DMA_LENGTH (DMA_LENGTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .queue_empty          (queue_empty),
      .pop                  (pop),
      .clearing             (clearing),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_read_data        (rsp_read_data),
      .rsp_forward_target   (rsp_forward_target),
      .rsp_forward_is_write (rsp_forward_is_write),
      .rsp_forward_address  (rsp_forward_address),
      .rsp_forward_data     (rsp_forward_data)
   );
endmodule

// ===== hdl/mmd_front.sv =====
// Front end: accepts bus transactions and tags each with its decoded region.
module mmd_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [15:0]        req_address,
   input  logic [7:0]         req_write_data,
   input  logic               queue_full,
   input  logic               clearing,
   output logic               push,
   output mmd_pkg::entry_type push_entry
);
   import mmd_pkg::*;

   // No transaction is taken while the back end sweeps its memories.
   assign req_ready = !queue_full && !clearing;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_entry.kind    = req_kind;
      push_entry.address = req_address;
      push_entry.data    = req_write_data;
      push_entry.region  = region_of(req_address);
   end
endmodule

// ===== hdl/mmd_queue.sv =====
// Short queue of decoded transactions between front and back end.
module mmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mmd_pkg::entry_type push_entry,
   input  logic               pop,
   output mmd_pkg::entry_type head,
   output logic               full,
   output logic               empty
);
   import mmd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]        count_ff, count_in;

   assign full  = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

// ===== hdl/mmd_back.sv =====
// Back end: memories, I/O file, object DMA engine and the result register.
module mmd_back #(
   parameter int DMA_LENGTH = 160
) (
   input  logic               clock,
   input  logic               reset,
   input  mmd_pkg::entry_type head,
   input  logic               queue_empty,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data,
   output logic [1:0]         rsp_forward_target,
   output logic               rsp_forward_is_write,
   output logic [15:0]        rsp_forward_address,
   output logic [7:0]         rsp_forward_data
);
   import mmd_pkg::*;

   state_type state_ff, state_in;

   logic [7:0] vram_mem [BANK_BYTES];
   logic [7:0] wram_mem [BANK_BYTES];
   logic [7:0] oam_mem  [OAM_BYTES];
   logic [7:0] io_mem   [IO_BYTES];
   logic [7:0] hram_mem [HIGH_BYTES];

   logic [7:0] vram_rd_ff, wram_rd_ff, oam_rd_ff, io_rd_ff, hram_rd_ff;
   logic [7:0] ie_ff, ie_in;
   region_type sel_rgn_ff;
   logic       sel_ok_ff;
   logic [7:0] sel_data;

   logic [BANK_AW-1:0] clr_ff, clr_in;
   logic [7:0]         page_ff, page_in;
   logic [OAM_AW-1:0]  idx_ff, idx_in;
   logic [15:0]        raddr;

   logic               vram_we, wram_we, oam_we, io_we, hram_we;
   logic [BANK_AW-1:0] bank_wa;
   logic [OAM_AW-1:0]  oam_wa;
   logic [IO_AW-1:0]   small_wa;
   logic [7:0]         vram_wd, wram_wd, oam_wd, io_wd, hram_wd;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rd_ff, rd_in;
   fwd_type     fwd_ff, fwd_in;
   logic        fwr_ff, fwr_in;
   logic [15:0] fad_ff, fad_in;
   logic [7:0]  fdt_ff, fdt_in;
   logic        load_fwd;

   logic is_dma_write;
   logic last_byte;

   assign is_dma_write = head.kind == KIND_WRITE && head.address == ADDR_DMA;
   assign last_byte    = idx_ff == OAM_AW'(DMA_LENGTH - 1);
   assign clearing     = state_ff == ST_CLEAR;

   // Data returned by the region that was addressed in the previous cycle.
   always_comb begin
      case (sel_rgn_ff)
         RGN_VRAM: sel_data = vram_rd_ff;
         RGN_WRAM: sel_data = wram_rd_ff;
         RGN_OAM:  sel_data = oam_rd_ff;
         RGN_IO:   sel_data = sel_ok_ff ? io_rd_ff : OPEN_BUS;
         RGN_HRAM: sel_data = hram_rd_ff;
         RGN_IE:   sel_data = ie_ff;
         default:  sel_data = OPEN_BUS;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == BANK_AW'(BANK_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!queue_empty && !rsp_valid_ff) begin
               if (head.kind == KIND_READ) state_in = ST_FETCH;
               else if (is_dma_write)      state_in = ST_DMA_RD;
            end
         end
         ST_FETCH:  state_in = ST_IDLE;
         ST_DMA_RD: state_in = ST_DMA_WR;
         ST_DMA_WR: state_in = last_byte ? ST_IDLE : ST_DMA_RD;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop      = 1'b0;
      raddr    = head.address;
      vram_we  = 1'b0;
      wram_we  = 1'b0;
      oam_we   = 1'b0;
      io_we    = 1'b0;
      hram_we  = 1'b0;
      bank_wa  = head.address[BANK_AW-1:0];
      oam_wa   = head.address[OAM_AW-1:0];
      small_wa = head.address[IO_AW-1:0];
      vram_wd  = head.data;
      wram_wd  = head.data;
      oam_wd   = head.data;
      io_wd    = head.data;
      hram_wd  = head.data;
      ie_in    = ie_ff;
      clr_in   = clr_ff;
      page_in  = page_ff;
      idx_in   = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_in    = rd_ff;
      load_fwd = 1'b0;
      fwd_in   = FWD_NONE;
      case (state_ff)
         ST_CLEAR: begin
            bank_wa  = clr_ff;
            oam_wa   = clr_ff[OAM_AW-1:0];
            small_wa = clr_ff[IO_AW-1:0];
            vram_we  = 1'b1;
            wram_we  = 1'b1;
            oam_we   = clr_ff < BANK_AW'(OAM_BYTES);
            io_we    = clr_ff < BANK_AW'(IO_BYTES);
            hram_we  = clr_ff < BANK_AW'(HIGH_BYTES);
            vram_wd  = 8'h00;
            wram_wd  = 8'h00;
            oam_wd   = 8'h00;
            hram_wd  = 8'h00;
            io_wd    = io_default(clr_ff[IO_AW-1:0]);
            clr_in   = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (!queue_empty && !rsp_valid_ff) begin
               pop      = 1'b1;
               load_fwd = 1'b1;
               if (head.kind == KIND_READ) begin
                  case (head.region)
                     RGN_CART:   fwd_in = FWD_CART;
                     RGN_JOYPAD: fwd_in = FWD_JOYPAD;
                     default:    fwd_in = FWD_NONE;
                  endcase
               end else begin
                  rsp_valid_in = 1'b1;
                  rd_in        = 8'h00;
                  case (head.region)
                     RGN_CART:   fwd_in = FWD_CART;
                     RGN_JOYPAD: fwd_in = FWD_JOYPAD;
                     RGN_VRAM:   vram_we = 1'b1;
                     RGN_WRAM:   wram_we = 1'b1;
                     RGN_OAM:    oam_we  = 1'b1;
                     RGN_HRAM:   hram_we = 1'b1;
                     RGN_IE:     ie_in   = head.data;
                     RGN_IO: begin
                        if (is_dma_write) begin
                           page_in = head.data;
                           idx_in  = '0;
                        end else begin
                           io_we = 1'b1;
                           if (head.address == ADDR_DIV) io_wd = 8'h00;
                           if (is_audio(head.address)) fwd_in = FWD_AUDIO;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_FETCH: begin
            rsp_valid_in = 1'b1;
            rd_in        = sel_data;
         end
         ST_DMA_RD: begin
            raddr = {page_ff, idx_ff};
         end
         ST_DMA_WR: begin
            oam_we = 1'b1;
            oam_wa = idx_ff;
            oam_wd = sel_data;
            idx_in = idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      fwr_in = (fwd_in != FWD_NONE) && head.kind == KIND_WRITE;
      fad_in = (fwd_in != FWD_NONE) ? head.address : 16'h0000;
      fdt_in = fwr_in ? head.data : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ie_ff        <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ie_ff        <= ie_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      idx_ff     <= idx_in;
      rd_ff      <= rd_in;
      sel_rgn_ff <= region_of(raddr);
      sel_ok_ff  <= io_readable(raddr[IO_AW-1:0]);
      if (load_fwd) begin
         fwd_ff <= fwd_in;
         fwr_ff <= fwr_in;
         fad_ff <= fad_in;
         fdt_ff <= fdt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vram_we) vram_mem[bank_wa] <= vram_wd;
      vram_rd_ff <= vram_mem[raddr[BANK_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wram_we) wram_mem[bank_wa] <= wram_wd;
      wram_rd_ff <= wram_mem[raddr[BANK_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (oam_we) oam_mem[oam_wa] <= oam_wd;
      oam_rd_ff <= oam_mem[raddr[OAM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (io_we) io_mem[small_wa] <= io_wd;
      io_rd_ff <= io_mem[raddr[IO_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (hram_we) hram_mem[small_wa[HIGH_AW-1:0]] <= hram_wd;
      hram_rd_ff <= hram_mem[raddr[HIGH_AW-1:0]];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rd_ff;
   assign rsp_forward_target   = fwd_ff;
   assign rsp_forward_is_write = fwr_ff;
   assign rsp_forward_address  = fad_ff;
   assign rsp_forward_data     = fdt_ff;
endmodule
